// ===== hw/rtl/drrip_pkg.sv =====
// ----------------------------------------------------------------------------
// DRRIP replacement package
// Field widths, reset values, codes and the command and status words that
// pass between the replacement controller and its datapath.
// ----------------------------------------------------------------------------
package drrip_pkg;

    localparam int SET_IN_W   = 11;
    localparam int WAY_IN_W   = 4;
    localparam int MASK_W     = 16;
    localparam int SEL_W      = 10;
    localparam int SHIFT_W    = 5;
    localparam int COUNT_W    = 20;
    localparam int CAUSE_W    = 2;
    localparam int CTR_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [CTR_W-1:0]   RR_MAX      = 2'd3;
    localparam logic [CTR_W-1:0]   RR_INIT     = 2'd2;
    localparam logic [CTR_W-1:0]   RR_INS_NEAR = 2'd2;
    localparam logic [CTR_W-1:0]   DEAD_SAT    = 2'd3;
    localparam logic [SEL_W-1:0]   SEL_MAX     = 10'd1023;
    localparam logic [SEL_W-1:0]   SEL_RESET   = 10'd512;
    localparam logic [SEL_W-1:0]   MID_RESET   = 10'd512;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

    localparam logic MODE_VICTIM = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    localparam logic [CAUSE_W-1:0] CAUSE_INVALID = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_DEAD    = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_REREF   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SHIFT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEL_MID     = 1'd1;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic swp_rd;
        logic swp_wr;
        logic row_rd;
        logic commit;
        logic cnt_inc;
        logic cnt_clr;
    } drrip_cmd_t;

    typedef struct packed {
        logic decay_due;
        logic cnt_last;
        logic out_free;
    } drrip_status_t;

endpackage

// ===== hw/rtl/drrip_ram.sv =====
// ----------------------------------------------------------------------------
// DRRIP row memory
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module drrip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/drrip_ctrl.sv =====
// ----------------------------------------------------------------------------
// DRRIP controller
// State machine that sequences the clearing pass, the decay sweep and the
// read, wait and execute steps of each input word.
// ----------------------------------------------------------------------------
module drrip_ctrl
    import drrip_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  drrip_status_t status,
    output drrip_cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_SWEEP_RD = 3'd2;
    localparam logic [2:0] ST_SWEEP_WR = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;
    localparam logic [2:0] ST_WAIT     = 3'd5;
    localparam logic [2:0] ST_EXEC     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.cnt_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.decay_due ? ST_SWEEP_RD : ST_READ;
                end
            end
            ST_SWEEP_RD:
            begin
                cmd.swp_rd = 1'b1;
                state_next = ST_SWEEP_WR;
            end
            ST_SWEEP_WR:
            begin
                cmd.swp_wr = 1'b1;
                if (status.cnt_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_READ;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_SWEEP_RD;
                end
            end
            ST_READ:
            begin
                cmd.row_rd = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && !status.out_free) |=> state_reg == ST_EXEC)
        else $error("result was dropped while the output word was held");

    a_decay_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && status.decay_due)
        |=> state_reg == ST_SWEEP_RD)
        else $error("decay sweep did not start ahead of the update");

endmodule

// ===== hw/rtl/drrip_datapath.sv =====
// ----------------------------------------------------------------------------
// DRRIP datapath
// Configuration, selector and update counter, row memory access, victim
// search, line update, decay of dead counters and the output register.
// ----------------------------------------------------------------------------
module drrip_datapath
    import drrip_pkg::*;
#(
    parameter int NUM_SETS       = 2048,
    parameter int NUM_WAYS       = 16,
    parameter int LEADER_MODULUS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  drrip_cmd_t                    cmd,
    output drrip_status_t                 status,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          mode,
    input  logic [SET_IN_W-1:0]           set_index,
    input  logic [WAY_IN_W-1:0]           way_index,
    input  logic                          was_hit,
    input  logic [MASK_W-1:0]             valid_mask,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [WAY_IN_W-1:0]           victim_way,
    output logic [CAUSE_W-1:0]            victim_cause,
    output logic [SEL_W-1:0]              selector_level,
    output logic                          rr_we,
    output logic                          rr_re,
    output logic [$clog2(NUM_SETS)-1:0]   rr_waddr,
    output logic [$clog2(NUM_SETS)-1:0]   rr_raddr,
    output logic [2*NUM_WAYS-1:0]         rr_wdata,
    input  logic [2*NUM_WAYS-1:0]         rr_rdata,
    output logic                          dd_we,
    output logic                          dd_re,
    output logic [$clog2(NUM_SETS)-1:0]   dd_waddr,
    output logic [$clog2(NUM_SETS)-1:0]   dd_raddr,
    output logic [2*NUM_WAYS-1:0]         dd_wdata,
    input  logic [2*NUM_WAYS-1:0]         dd_rdata
);

    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int WAY_W      = $clog2(NUM_WAYS);
    localparam int ROW_W      = 2 * NUM_WAYS;
    localparam int MASK_EXT_W = (NUM_WAYS > MASK_W) ? NUM_WAYS : MASK_W;
    localparam longint unsigned RECIP_WIDE = (64'd1 << 32) / 64'(LEADER_MODULUS);
    localparam logic [31:0] RECIP = 32'(RECIP_WIDE);
    localparam logic [ROW_W-1:0] REREF_INIT = {NUM_WAYS{RR_INIT}};

    function automatic logic [SET_W-1:0] set_mod(input logic [SET_IN_W-1:0] s);
        logic [SET_IN_W-1:0] r;
        r = s;
        for (int k = 4; k >= 0; k--)
        begin
            if (32'(r) >= (32'(NUM_SETS) << k))
            begin
                r = SET_IN_W'(32'(r) - (32'(NUM_SETS) << k));
            end
        end
        return SET_W'(r);
    endfunction

    function automatic logic [WAY_W-1:0] way_mod(input logic [WAY_IN_W-1:0] w);
        logic [WAY_IN_W-1:0] r;
        r = w;
        for (int k = 2; k >= 0; k--)
        begin
            if (32'(r) >= (32'(NUM_WAYS) << k))
            begin
                r = WAY_IN_W'(32'(r) - (32'(NUM_WAYS) << k));
            end
        end
        return WAY_W'(r);
    endfunction

    function automatic logic [WAY_W-1:0] first_one(input logic [NUM_WAYS-1:0] v);
        logic [WAY_W-1:0] idx;
        idx = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (v[w])
            begin
                idx = WAY_W'(w);
            end
        end
        return idx;
    endfunction

    logic [SHIFT_W-1:0]    decay_shift_reg;
    logic [SEL_W-1:0]      sel_mid_reg;
    logic [SEL_W-1:0]      sel_reg;
    logic [SEL_W-1:0]      sel_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  mode_reg;
    logic [SET_W-1:0]      set_reg;
    logic [WAY_W-1:0]      way_reg;
    logic                  hit_reg;
    logic [MASK_W-1:0]     mask_reg;
    logic [SET_W-1:0]      cnt_reg;
    logic [SET_W+31:0]     prod_reg;
    logic [SET_W-1:0]      ql_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [WAY_IN_W-1:0]   victim_way_reg;
    logic [CAUSE_W-1:0]    victim_cause_reg;
    logic [SEL_W-1:0]      sel_level_reg;

    logic [SHIFT_W-1:0]    shift_eff;
    logic [COUNT_W-1:0]    decay_mask;
    logic [SET_W-1:0]      q_est;
    logic [SET_W-1:0]      rem_raw;
    logic [SET_W-1:0]      rem;
    logic                  is_srrip;
    logic                  is_brrip;
    logic [MASK_EXT_W-1:0] mask_ext;
    logic [NUM_WAYS-1:0]   inv_vec;
    logic [NUM_WAYS-1:0]   dead_vec;
    logic [NUM_WAYS-1:0]   top_vec;
    logic [NUM_WAYS-1:0]   has3;
    logic [NUM_WAYS-1:0]   has2;
    logic [NUM_WAYS-1:0]   has1;
    logic [CTR_W-1:0]      top;
    logic [CTR_W-1:0]      age_step;
    logic [ROW_W-1:0]      rr_aged_row;
    logic [ROW_W-1:0]      rr_upd_row;
    logic [ROW_W-1:0]      dd_upd_row;
    logic [ROW_W-1:0]      dd_decayed_row;
    logic [CTR_W-1:0]      dead_old;
    logic [CTR_W-1:0]      dead_new;
    logic [CTR_W-1:0]      ins;
    logic [WAY_W-1:0]      vic_way;
    logic [CAUSE_W-1:0]    vic_cause;
    logic                  is_update;

    assign is_update = (mode_reg == MODE_UPDATE);

    // Decay trigger for the update word now at the input.
    always_comb
    begin
        shift_eff  = (decay_shift_reg > SHIFT_W'(COUNT_W)) ? SHIFT_W'(COUNT_W)
                                                           : decay_shift_reg;
        decay_mask = COUNT_W'(((COUNT_W + 1)'(1) << shift_eff) - (COUNT_W + 1)'(1));
        count_next = count_reg + COUNT_W'(1);
    end

    assign status.decay_due = (mode == MODE_UPDATE) && ((count_next & decay_mask) == '0);
    assign status.cnt_last  = (cnt_reg == SET_W'(NUM_SETS - 1));
    assign status.out_free  = !out_valid_reg || !out_stall;

    // Leader group: set modulo the leader modulus by reciprocal multiply.
    assign q_est   = prod_reg[SET_W+31:32];
    assign rem_raw = set_reg - ql_reg;
    assign rem     = (32'(rem_raw) >= 32'(LEADER_MODULUS))
                     ? SET_W'(32'(rem_raw) - 32'(LEADER_MODULUS)) : rem_raw;
    assign is_srrip = (rem == '0);
    assign is_brrip = (rem == SET_W'(1));

    // Victim search over the row read from memory.
    always_comb
    begin
        mask_ext               = '1;
        mask_ext[MASK_W-1:0]   = mask_reg;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            inv_vec[w]  = ~mask_ext[w];
            dead_vec[w] = (dd_rdata[2*w +: 2] == DEAD_SAT);
            has3[w]     = (rr_rdata[2*w +: 2] == 2'd3);
            has2[w]     = (rr_rdata[2*w +: 2] == 2'd2);
            has1[w]     = (rr_rdata[2*w +: 2] == 2'd1);
        end
        if (|has3)
        begin
            top = 2'd3;
        end
        else if (|has2)
        begin
            top = 2'd2;
        end
        else if (|has1)
        begin
            top = 2'd1;
        end
        else
        begin
            top = 2'd0;
        end
        age_step = RR_MAX - top;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            top_vec[w]            = (rr_rdata[2*w +: 2] == top);
            rr_aged_row[2*w +: 2] = rr_rdata[2*w +: 2] + age_step;
        end
        if (|inv_vec)
        begin
            vic_way   = first_one(inv_vec);
            vic_cause = CAUSE_INVALID;
        end
        else if (|dead_vec)
        begin
            vic_way   = first_one(dead_vec);
            vic_cause = CAUSE_DEAD;
        end
        else
        begin
            vic_way   = first_one(top_vec);
            vic_cause = CAUSE_REREF;
        end
    end

    // Line update, insertion value and selector movement.
    always_comb
    begin
        dead_old = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (way_reg == WAY_W'(w))
            begin
                dead_old = dd_rdata[2*w +: 2];
            end
        end
        if (hit_reg)
        begin
            dead_new = '0;
        end
        else if (dead_old == DEAD_SAT)
        begin
            dead_new = DEAD_SAT;
        end
        else
        begin
            dead_new = dead_old + CTR_W'(1);
        end
        if (is_srrip)
        begin
            ins = RR_INS_NEAR;
        end
        else if (is_brrip)
        begin
            ins = RR_MAX;
        end
        else
        begin
            ins = (sel_reg >= sel_mid_reg) ? RR_INS_NEAR : RR_MAX;
        end
        if (dead_new == DEAD_SAT)
        begin
            ins = RR_MAX;
        end
        rr_upd_row = rr_rdata;
        dd_upd_row = dd_rdata;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (way_reg == WAY_W'(w))
            begin
                rr_upd_row[2*w +: 2] = ins;
                dd_upd_row[2*w +: 2] = dead_new;
            end
            dd_decayed_row[2*w +: 2] = (dd_rdata[2*w +: 2] != '0)
                                       ? dd_rdata[2*w +: 2] - CTR_W'(1) : '0;
        end
        sel_next = sel_reg;
        if (!hit_reg)
        begin
            if (is_srrip && sel_reg != SEL_MAX)
            begin
                sel_next = sel_reg + SEL_W'(1);
            end
            else if (is_brrip && sel_reg != '0)
            begin
                sel_next = sel_reg - SEL_W'(1);
            end
        end
    end

    // Memory ports.
    assign rr_raddr = set_reg;
    assign dd_raddr = cmd.swp_rd ? cnt_reg : set_reg;
    assign rr_waddr = cmd.clr_wr ? cnt_reg : set_reg;
    assign dd_waddr = (cmd.clr_wr || cmd.swp_wr) ? cnt_reg : set_reg;
    assign rr_re    = cmd.row_rd;
    assign dd_re    = cmd.row_rd || cmd.swp_rd;
    assign rr_we    = cmd.clr_wr
                      || (cmd.commit && (is_update || vic_cause == CAUSE_REREF));
    assign dd_we    = cmd.clr_wr || cmd.swp_wr || (cmd.commit && is_update);
    assign rr_wdata = cmd.clr_wr ? REREF_INIT : (is_update ? rr_upd_row : rr_aged_row);
    assign dd_wdata = cmd.clr_wr ? '0 : (cmd.swp_wr ? dd_decayed_row : dd_upd_row);

    assign out_valid_next = cmd.commit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_shift_reg <= SHIFT_RESET;
            sel_mid_reg     <= MID_RESET;
            sel_reg         <= SEL_RESET;
            count_reg       <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            mode_reg        <= MODE_VICTIM;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_DECAY_SHIFT)
            begin
                decay_shift_reg <= cfg_data[SHIFT_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_SEL_MID)
            begin
                sel_mid_reg <= cfg_data[SEL_W-1:0];
            end
            if (cmd.load)
            begin
                mode_reg <= mode;
                if (mode == MODE_UPDATE)
                begin
                    count_reg <= count_next;
                end
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + SET_W'(1);
            end
            if (cmd.commit && is_update)
            begin
                sel_reg <= sel_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            set_reg  <= set_mod(set_index);
            way_reg  <= way_mod(way_index);
            hit_reg  <= was_hit;
            mask_reg <= valid_mask;
        end
        prod_reg <= (SET_W + 32)'(set_reg) * (SET_W + 32)'(RECIP);
        ql_reg   <= SET_W'((SET_W + 11)'(q_est) * (SET_W + 11)'(LEADER_MODULUS));
        if (cmd.commit)
        begin
            if (is_update)
            begin
                victim_way_reg   <= '0;
                victim_cause_reg <= CAUSE_INVALID;
                sel_level_reg    <= sel_next;
            end
            else
            begin
                victim_way_reg   <= WAY_IN_W'(vic_way);
                victim_cause_reg <= vic_cause;
                sel_level_reg    <= sel_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign victim_way     = victim_way_reg;
    assign victim_cause   = victim_cause_reg;
    assign selector_level = sel_level_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("result written over an untaken output word");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_sel_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(sel_reg))
        else $error("selector moved outside an update");

endmodule

// ===== hw/rtl/drrip_dead_block_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// DRRIP dead-block replacement unit
// Last-level cache replacement controller with set dueling and a dead-line
// predictor.
//
// Usage: the input channel (in_valid, in_stall) carries one word per access:
// mode 0 asks for a victim way in set_index given valid_mask, mode 1 records
// an access to way_index with was_hit. The output channel (out_valid,
// out_stall) returns one word for each input word: victim way and cause, or
// zeros in update mode, and the policy selector after the step.
// After a word is accepted, the READ state reads both rows, the WAIT state
// lets the leader-group multiply finish, and the EXEC state executes, writes
// back the row and registers the result word, holding while the output word
// is untaken; a new word is accepted only once the block is back in idle.
// Every 2^decay_shift updates (a decay_shift above 20 acts as 20) an update
// word first runs a decay sweep that reads and rewrites each dead-counter row.
// After reset the unit clears both row memories, one row per cycle, and
// holds in_stall high until done; configuration writes are taken at any time.
// A stalled result word stays in the output register while the next word is
// accepted and processed up to its write-back step.
// ----------------------------------------------------------------------------
module drrip_dead_block_replacement_unit
    import drrip_pkg::*;
#(
    parameter int NUM_SETS       = 2048,
    parameter int NUM_WAYS       = 16,
    parameter int LEADER_MODULUS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [SET_IN_W-1:0]   set_index,
    input  logic [WAY_IN_W-1:0]   way_index,
    input  logic                  was_hit,
    input  logic [MASK_W-1:0]     valid_mask,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [WAY_IN_W-1:0]   victim_way,
    output logic [CAUSE_W-1:0]    victim_cause,
    output logic [SEL_W-1:0]      selector_level
);

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int ROW_W = 2 * NUM_WAYS;

    drrip_cmd_t    cmd;
    drrip_status_t status;

    logic             rr_we;
    logic             rr_re;
    logic [SET_W-1:0] rr_waddr;
    logic [SET_W-1:0] rr_raddr;
    logic [ROW_W-1:0] rr_wdata;
    logic [ROW_W-1:0] rr_rdata;
    logic             dd_we;
    logic             dd_re;
    logic [SET_W-1:0] dd_waddr;
    logic [SET_W-1:0] dd_raddr;
    logic [ROW_W-1:0] dd_wdata;
    logic [ROW_W-1:0] dd_rdata;

    drrip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    drrip_datapath #(
        .NUM_SETS       (NUM_SETS),
        .NUM_WAYS       (NUM_WAYS),
        .LEADER_MODULUS (LEADER_MODULUS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .set_index      (set_index),
        .way_index      (way_index),
        .was_hit        (was_hit),
        .valid_mask     (valid_mask),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .victim_way     (victim_way),
        .victim_cause   (victim_cause),
        .selector_level (selector_level),
        .rr_we          (rr_we),
        .rr_re          (rr_re),
        .rr_waddr       (rr_waddr),
        .rr_raddr       (rr_raddr),
        .rr_wdata       (rr_wdata),
        .rr_rdata       (rr_rdata),
        .dd_we          (dd_we),
        .dd_re          (dd_re),
        .dd_waddr       (dd_waddr),
        .dd_raddr       (dd_raddr),
        .dd_wdata       (dd_wdata),
        .dd_rdata       (dd_rdata)
    );

    drrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_reref_ram (
        .clk   (clk),
        .we    (rr_we),
        .waddr (rr_waddr),
        .wdata (rr_wdata),
        .re    (rr_re),
        .raddr (rr_raddr),
        .rdata (rr_rdata)
    );

    drrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_dead_ram (
        .clk   (clk),
        .we    (dd_we),
        .waddr (dd_waddr),
        .wdata (dd_wdata),
        .re    (dd_re),
        .raddr (dd_raddr),
        .rdata (dd_rdata)
    );

endmodule

// ===== verif/tb_drrip_dead_block_replacement_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the DRRIP dead-block replacement unit
// Drives victim and update words through the input channel and keeps its own
// copy of the re-reference values, dead counters and policy selector to
// predict every result word. Directed cases come first, then random phases
// that sweep the decay period, the selector midpoint and the selector
// across both saturation points, under varied idling and output stalls.
// ----------------------------------------------------------------------------
module tb_drrip_dead_block_replacement_unit;
    import drrip_pkg::*;

    localparam int NUM_SETS       = 2048;
    localparam int NUM_WAYS       = 16;
    localparam int LEADER_MODULUS = 32;
    localparam int GROUP_W        = 5;
    localparam int MAX_SHIFT      = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;

    localparam logic [GROUP_W-1:0] NEAR_LEADER = 5'd0;
    localparam logic [GROUP_W-1:0] FAR_LEADER  = 5'd1;

    typedef struct packed {
        logic [WAY_IN_W-1:0] way;
        logic [CAUSE_W-1:0]  cause;
        logic [SEL_W-1:0]    level;
    } choice_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic                  mode           = MODE_VICTIM;
    logic [SET_IN_W-1:0]   set_index      = '0;
    logic [WAY_IN_W-1:0]   way_index      = '0;
    logic                  was_hit        = 1'b0;
    logic [MASK_W-1:0]     valid_mask     = '0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [WAY_IN_W-1:0]   victim_way;
    logic [CAUSE_W-1:0]    victim_cause;
    logic [SEL_W-1:0]      selector_level;

    logic [CTR_W-1:0]   rrpv_mem    [NUM_SETS][NUM_WAYS];
    logic [CTR_W-1:0]   deadctr_mem [NUM_SETS][NUM_WAYS];
    logic [SEL_W-1:0]   psel_q      = SEL_RESET;
    logic [COUNT_W-1:0] upd_count_q = '0;
    logic [SHIFT_W-1:0] shift_q     = SHIFT_RESET;
    logic [SEL_W-1:0]   mid_q       = MID_RESET;

    choice_t awaited_choices [$];
    choice_t oldest_choice;
    int      error_count = 0;
    int      idle_pct    = 0;
    int      stall_pct   = 0;
    logic    hold_req    = 1'b0;
    int      hold_left   = 0;

    drrip_dead_block_replacement_unit #(
        .NUM_SETS       (NUM_SETS),
        .NUM_WAYS       (NUM_WAYS),
        .LEADER_MODULUS (LEADER_MODULUS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .set_index      (set_index),
        .way_index      (way_index),
        .was_hit        (was_hit),
        .valid_mask     (valid_mask),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .victim_way     (victim_way),
        .victim_cause   (victim_cause),
        .selector_level (selector_level)
    );

    always #6 clk = ~clk;

    // The long hold-off is counted here, apart from the sender.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        out_stall <= (hold_left != 0) || hold_req || ($urandom_range(99, 0) < stall_pct);
    end

    // Outputs are sampled at the falling edge, so a word seen here with stall low
    // is taken at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_choices.size() == 0)
            begin
                $error("result word with no access waiting for it");
                error_count++;
            end
            else
            begin
                oldest_choice = awaited_choices.pop_front();
                if (victim_way !== oldest_choice.way)
                begin
                    $error("victim_way: expected %0d, got %0d", oldest_choice.way, victim_way);
                    error_count++;
                end
                if (victim_cause !== oldest_choice.cause)
                begin
                    $error("victim_cause: expected %0d, got %0d",
                           oldest_choice.cause, victim_cause);
                    error_count++;
                end
                if (selector_level !== oldest_choice.level)
                begin
                    $error("selector_level: expected %0d, got %0d",
                           oldest_choice.level, selector_level);
                    error_count++;
                end
            end
        end
    end

    function automatic choice_t predict_access(input logic m, input logic [SET_IN_W-1:0] s,
                                               input logic [WAY_IN_W-1:0] w, input logic h,
                                               input logic [MASK_W-1:0] vm);
        choice_t            res;
        logic [CTR_W-1:0]   top;
        logic [CTR_W-1:0]   ins;
        logic [COUNT_W-1:0] low_mask;
        int                 eff;
        bit                 found;
        res = '0;
        found = 1'b0;
        if (m == MODE_VICTIM)
        begin
            for (int i = 0; i < NUM_WAYS && !found; i++)
                if (!vm[i])
                begin
                    res.way = WAY_IN_W'(i);
                    res.cause = CAUSE_INVALID;
                    found = 1'b1;
                end
            for (int i = 0; i < NUM_WAYS && !found; i++)
                if (deadctr_mem[s][i] == DEAD_SAT)
                begin
                    res.way = WAY_IN_W'(i);
                    res.cause = CAUSE_DEAD;
                    found = 1'b1;
                end
            if (!found)
            begin
                top = '0;
                for (int i = 0; i < NUM_WAYS; i++)
                    if (rrpv_mem[s][i] > top)
                        top = rrpv_mem[s][i];
                for (int i = 0; i < NUM_WAYS; i++)
                    rrpv_mem[s][i] = rrpv_mem[s][i] + (RR_MAX - top);
                res.cause = CAUSE_REREF;
                for (int i = 0; i < NUM_WAYS && !found; i++)
                    if (rrpv_mem[s][i] == RR_MAX)
                    begin
                        res.way = WAY_IN_W'(i);
                        found = 1'b1;
                    end
            end
        end
        else
        begin
            upd_count_q = upd_count_q + 1'b1;
            eff = (shift_q > MAX_SHIFT) ? MAX_SHIFT : int'(shift_q);
            low_mask = COUNT_W'((64'd1 << eff) - 64'd1);
            if ((upd_count_q & low_mask) == '0)
                for (int i = 0; i < NUM_SETS; i++)
                    for (int j = 0; j < NUM_WAYS; j++)
                        if (deadctr_mem[i][j] != '0)
                            deadctr_mem[i][j] = deadctr_mem[i][j] - 1'b1;
            if (h)
                deadctr_mem[s][w] = '0;
            else if (deadctr_mem[s][w] != DEAD_SAT)
                deadctr_mem[s][w] = deadctr_mem[s][w] + 1'b1;
            if (s[GROUP_W-1:0] == NEAR_LEADER)
                ins = RR_INS_NEAR;
            else if (s[GROUP_W-1:0] == FAR_LEADER)
                ins = RR_MAX;
            else
                ins = (psel_q >= mid_q) ? RR_INS_NEAR : RR_MAX;
            if (deadctr_mem[s][w] == DEAD_SAT)
                ins = RR_MAX;
            rrpv_mem[s][w] = ins;
            if (!h)
            begin
                if (s[GROUP_W-1:0] == NEAR_LEADER && psel_q != SEL_MAX)
                    psel_q = psel_q + 1'b1;
                if (s[GROUP_W-1:0] == FAR_LEADER && psel_q != '0)
                    psel_q = psel_q - 1'b1;
            end
        end
        res.level = psel_q;
        return res;
    endfunction

    task automatic send_access(input logic m, input logic [SET_IN_W-1:0] s,
                               input logic [WAY_IN_W-1:0] w, input logic h,
                               input logic [MASK_W-1:0] vm);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        set_index  <= s;
        way_index  <= w;
        was_hit    <= h;
        valid_mask <= vm;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        awaited_choices.push_back(predict_access(m, s, w, h, vm));
    endtask

    task automatic send_random_access(input int update_pct, input int push_pct,
                                      input logic [GROUP_W-1:0] push_group);
        logic                m;
        logic [SET_IN_W-1:0] s;
        logic [WAY_IN_W-1:0] w;
        logic                h;
        logic [MASK_W-1:0]   vm;
        s = SET_IN_W'($urandom);
        w = WAY_IN_W'($urandom);
        h = ($urandom_range(99, 0) < 40);
        m = ($urandom_range(99, 0) < update_pct) ? MODE_UPDATE : MODE_VICTIM;
        case ($urandom_range(3, 0))
            0, 1: vm = '1;
            2:
            begin
                vm = '1;
                vm[$urandom_range(NUM_WAYS - 1, 0)] = 1'b0;
            end
            default: vm = MASK_W'($urandom);
        endcase
        if ($urandom_range(99, 0) < push_pct)
        begin
            m = MODE_UPDATE;
            h = 1'b0;
            s[GROUP_W-1:0] = push_group;
        end
        else if ($urandom_range(2, 0) == 0)
            s = SET_IN_W'($urandom_range(7, 0) * LEADER_MODULUS + $urandom_range(3, 0));
        send_access(m, s, w, h, vm);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        while (awaited_choices.size() != 0)
            @(posedge clk);
    endtask

    // The upper bits of the decay word are filled with noise; only the low bits count.
    task automatic program_regs(input logic [SHIFT_W-1:0] shift_val,
                                input logic [SEL_W-1:0] mid_val);
        logic [CFG_DATA_W-1:0] shift_word;
        shift_word = CFG_DATA_W'($urandom);
        shift_word[SHIFT_W-1:0] = shift_val;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DECAY_SHIFT;
        cfg_data  <= shift_word;
        @(posedge clk);
        cfg_index <= CFG_SEL_MID;
        cfg_data  <= CFG_DATA_W'(mid_val);
        @(posedge clk);
        cfg_we <= 1'b0;
        shift_q = shift_val;
        mid_q = mid_val;
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_access(MODE_VICTIM, 11'd0, 4'd7, 1'b1, 16'h0000);
        send_access(MODE_VICTIM, 11'd2047, 4'd0, 1'b0, 16'h7FFF);
        send_access(MODE_VICTIM, 11'd6, 4'd0, 1'b0, 16'hAAAA);
        send_access(MODE_VICTIM, 11'd6, 4'd0, 1'b0, 16'h5555);
        send_access(MODE_VICTIM, 11'd5, 4'd15, 1'b1, 16'hFFFF);
        send_access(MODE_VICTIM, 11'd5, 4'd0, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd0, 4'd3, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd1, 4'd15, 1'b0, 16'h0000);
        send_access(MODE_UPDATE, 11'd33, 4'd0, 1'b1, 16'h1234);
        send_access(MODE_UPDATE, 11'd70, 4'd9, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd70, 4'd9, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd70, 4'd9, 1'b0, 16'hFFFF);
        send_access(MODE_VICTIM, 11'd70, 4'd0, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd70, 4'd9, 1'b1, 16'hFFFF);
        send_access(MODE_VICTIM, 11'd70, 4'd0, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd2047, 4'd15, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd64, 4'd0, 1'b1, 16'hFFFF);
        send_access(MODE_VICTIM, 11'd2047, 4'd15, 1'b1, 16'hFFFF);
        send_access(MODE_VICTIM, 11'd2047, 4'd15, 1'b1, 16'hFFFE);
        drain_replies();
    endtask

    task automatic test_decay_corners();
        idle_pct = 0;
        stall_pct = 0;
        program_regs(5'd0, 10'd1023);
        send_access(MODE_UPDATE, 11'd98, 4'd2, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd98, 4'd2, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd96, 4'd5, 1'b0, 16'hFFFF);
        send_access(MODE_VICTIM, 11'd98, 4'd0, 1'b0, 16'hFFFF);
        drain_replies();
        program_regs(5'd1, 10'd0);
        send_access(MODE_UPDATE, 11'd98, 4'd2, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd98, 4'd2, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd98, 4'd4, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd98, 4'd2, 1'b0, 16'hFFFF);
        send_access(MODE_VICTIM, 11'd98, 4'd0, 1'b0, 16'hFFFF);
        drain_replies();
        program_regs(5'd31, 10'd1023);
        send_access(MODE_UPDATE, 11'd99, 4'd1, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd99, 4'd1, 1'b0, 16'hFFFF);
        send_access(MODE_UPDATE, 11'd99, 4'd1, 1'b0, 16'hFFFF);
        send_access(MODE_VICTIM, 11'd99, 4'd0, 1'b0, 16'hFFFF);
        drain_replies();
    endtask

    task automatic test_random_mix(input int count, input logic [SHIFT_W-1:0] shift_val,
                                   input logic [SEL_W-1:0] mid_val, input int idle,
                                   input int stall);
        program_regs(shift_val, mid_val);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count)
            send_random_access(50, 0, NEAR_LEADER);
        drain_replies();
    endtask

    // Leader misses walk the selector to one end, then a few more words sit at the limit.
    task automatic test_selector_sweep(input logic [SEL_W-1:0] target,
                                       input logic [GROUP_W-1:0] group,
                                       input logic [SHIFT_W-1:0] shift_val,
                                       input logic [SEL_W-1:0] mid_val, input int idle,
                                       input int stall);
        program_regs(shift_val, mid_val);
        idle_pct = idle;
        stall_pct = stall;
        while (psel_q != target)
            send_random_access(50, 96, group);
        repeat (16)
            send_random_access(50, 96, group);
        drain_replies();
    endtask

    task automatic test_backpressure();
        program_regs(SHIFT_RESET, MID_RESET);
        idle_pct = 0;
        stall_pct = 0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (24)
            send_random_access(50, 0, NEAR_LEADER);
        drain_replies();
    endtask

    initial
    begin
        for (int i = 0; i < NUM_SETS; i++)
            for (int j = 0; j < NUM_WAYS; j++)
            begin
                rrpv_mem[i][j] = RR_INIT;
                deadctr_mem[i][j] = '0;
            end
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_decay_corners();
        test_random_mix(120, 5'd20, 10'd0, 0, 0);
        test_selector_sweep(SEL_MAX, NEAR_LEADER, 5'd9, 10'd1023, 84, 0);
        test_random_mix(100, 5'd6, 10'd700, 0, 84);
        test_selector_sweep('0, FAR_LEADER, 5'd10, 10'd300, 29, 29);
        test_backpressure();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0 && awaited_choices.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== drrip_dead_block_replacement_unit.f =====
hw/rtl/drrip_pkg.sv
hw/rtl/drrip_ram.sv
hw/rtl/drrip_ctrl.sv
hw/rtl/drrip_datapath.sv
hw/rtl/drrip_dead_block_replacement_unit.sv
verif/tb_drrip_dead_block_replacement_unit.sv
